// ===== rtl/arcint_pkg.sv =====
// Shared types and constants for the clockwise arc step interpolator.
// No dependencies; imported by circular_arc_step_interpolator.
`default_nettype none

package arcint_pkg;

	// Coordinate and move count widths inside the block
	localparam int COORD_BITS = 16;
	localparam int COUNT_BITS = 16;
	// Squared radius holds x*x + y*y without overflow
	localparam int SQ_BITS    = 2 * COORD_BITS + 1;

	// Item kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	// Axis codes
	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	// Direction codes
	localparam logic DIR_NEG = 1'b0;
	localparam logic DIR_POS = 1'b1;

	typedef logic [1:0]                   kind_t;
	typedef logic signed [15:0]           field16_t;
	typedef logic [15:0]                  ufield16_t;
	typedef logic [7:0]                   pulse_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COUNT_BITS-1:0]        count_t;
	typedef logic [SQ_BITS-1:0]           sq_t;

	// Coordinate limits
	localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

endpackage

`default_nettype wire

// ===== rtl/circular_arc_step_interpolator.sv =====
// The result of a beat is registered and is in the output register the cycle after it.
// Throughput: one beat per cycle; the two squarers and the radius compare are
// combinational. A new beat enters as the previous result leaves; while a result waits
// under out_stall the input stalls. Reset clears position, radius, move count, arc state
// and output valid, and sets pulses_per_move to 1.
// Clockwise point-by-point comparison arc interpolator; imports arcint_pkg.
`default_nettype none

module circular_arc_step_interpolator (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_wr_en,
	input  wire arcint_pkg::pulse_t    cfg_wr_data,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire arcint_pkg::kind_t     kind,
	input  wire arcint_pkg::field16_t  x_offset,
	input  wire arcint_pkg::field16_t  y_offset,
	input  wire arcint_pkg::ufield16_t move_count,
	// output channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       moved,
	output logic                       axis,
	output logic                       direction,
	output arcint_pkg::pulse_t         pulse_count,
	output arcint_pkg::field16_t       x_position,
	output arcint_pkg::field16_t       y_position,
	output logic                       done_res
);

	import arcint_pkg::*;

	// Saturate a 16-bit offset to the coordinate range
	function automatic coord_t sat_offset(input field16_t v);
		logic signed [31:0] w;
		logic signed [31:0] hi;
		logic signed [31:0] lo;
		w  = 32'(v);
		hi = 32'(CMAX);
		lo = 32'(CMIN);
		if (w > hi) begin
			return CMAX;
		end else if (w < lo) begin
			return CMIN;
		end
		return w[COORD_BITS-1:0];
	endfunction

	// One unit step with saturation at the coordinate limits
	function automatic coord_t step_coord(input coord_t c, input logic up);
		if (up) begin
			return (c == CMAX) ? CMAX : coord_t'(c + coord_t'(1));
		end
		return (c == CMIN) ? CMIN : coord_t'(c - coord_t'(1));
	endfunction

	// Bring a coordinate to the 16-bit port
	function automatic field16_t to_port(input coord_t c);
		logic signed [31:0] w;
		w = 32'(c);
		return w[15:0];
	endfunction

	// State
	logic   [7:0]  ppm_q;
	coord_t        x_q;
	coord_t        y_q;
	sq_t           r2_q;
	count_t        left_q;
	logic          active_q;

	// Result register
	logic          out_valid_q;
	logic          moved_q;
	logic          axis_q;
	logic          dir_q;
	pulse_t        pulse_q;
	field16_t      xpos_q;
	field16_t      ypos_q;
	logic          done_q;

	logic          accept;

	// Next-state and result terms
	coord_t        x_start;
	coord_t        y_start;
	count_t        cnt_start;
	coord_t        sq_x_in;
	coord_t        sq_y_in;
	logic signed [2*COORD_BITS-1:0] x_sq;
	logic signed [2*COORD_BITS-1:0] y_sq;
	sq_t           sq_sum;
	logic          outside;
	logic          x_neg;
	logic          y_neg;
	logic          x_zero;
	logic          y_zero;
	logic          mv;
	logic          ax;
	logic          dr;
	coord_t        x_nxt;
	coord_t        y_nxt;
	sq_t           r2_nxt;
	count_t        left_nxt;
	logic          active_nxt;

	// Take a beat when the output register is free or draining
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Start operands
	always_comb begin
		logic [47:0] cnt_w;
		cnt_w     = 48'(move_count);
		x_start   = sat_offset(x_offset);
		y_start   = sat_offset(y_offset);
		cnt_start = cnt_w[COUNT_BITS-1:0];
	end

	// Squarers shared between radius latch on start and comparison on tick
	assign sq_x_in = (kind == KIND_START) ? x_start : x_q;
	assign sq_y_in = (kind == KIND_START) ? y_start : y_q;
	assign x_sq    = sq_x_in * sq_x_in;
	assign y_sq    = sq_y_in * sq_y_in;
	assign sq_sum  = SQ_BITS'(unsigned'(x_sq)) + SQ_BITS'(unsigned'(y_sq));
	assign outside = (sq_sum >= r2_q);

	assign x_neg  = x_q[COORD_BITS-1];
	assign y_neg  = y_q[COORD_BITS-1];
	assign x_zero = (x_q == '0);
	assign y_zero = (y_q == '0);

	// Pick the quadrant rule and compute the next state
	always_comb begin
		mv         = 1'b0;
		ax         = AXIS_X;
		dr         = DIR_NEG;
		x_nxt      = x_q;
		y_nxt      = y_q;
		r2_nxt     = r2_q;
		left_nxt   = left_q;
		active_nxt = active_q;
		unique case (kind)
			KIND_START: begin
				x_nxt      = x_start;
				y_nxt      = y_start;
				r2_nxt     = sq_sum;
				left_nxt   = cnt_start;
				active_nxt = (cnt_start != '0);
			end
			KIND_TICK: begin
				if (active_q) begin
					mv = 1'b1;
					priority if (!x_neg && !y_neg && !y_zero) begin
						ax = outside ? AXIS_Y : AXIS_X;
						dr = outside ? DIR_NEG : DIR_POS;
					end else if (x_neg && !y_neg) begin
						ax = outside ? AXIS_X : AXIS_Y;
						dr = DIR_POS;
					end else if ((x_neg || x_zero) && y_neg) begin
						ax = outside ? AXIS_Y : AXIS_X;
						dr = outside ? DIR_POS : DIR_NEG;
					end else if (!x_neg && !x_zero && (y_neg || y_zero)) begin
						ax = outside ? AXIS_X : AXIS_Y;
						dr = DIR_NEG;
					end else begin
						// at the centre: no move, count still drops
						mv = 1'b0;
					end
					if (mv && ax == AXIS_X) begin
						x_nxt = step_coord(x_q, dr);
					end
					if (mv && ax == AXIS_Y) begin
						y_nxt = step_coord(y_q, dr);
					end
					left_nxt   = left_q - count_t'(1);
					active_nxt = (left_nxt != '0);
				end
			end
			KIND_STOP: begin
				active_nxt = 1'b0;
				left_nxt   = '0;
			end
			default: begin
				// unused kind: hold everything
			end
		endcase
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppm_q <= 8'd1;
		end else if (cfg_wr_en) begin
			ppm_q <= cfg_wr_data;
		end
	end

	// Arc state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			r2_q     <= '0;
			left_q   <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			x_q      <= x_nxt;
			y_q      <= y_nxt;
			r2_q     <= r2_nxt;
			left_q   <= left_nxt;
			active_q <= active_nxt;
		end
	end

	// Output valid: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			moved_q <= mv;
			axis_q  <= ax;
			dir_q   <= dr;
			pulse_q <= mv ? ppm_q : 8'd0;
			xpos_q  <= to_port(x_nxt);
			ypos_q  <= to_port(y_nxt);
			done_q  <= !active_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign moved       = moved_q;
	assign axis        = axis_q;
	assign direction   = dir_q;
	assign pulse_count = pulse_q;
	assign x_position  = xpos_q;
	assign y_position  = ypos_q;
	assign done_res    = done_q;

	// An arc runs exactly while moves remain
	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q == (left_q != '0))
		else $error("arc state and move count disagree");

	// A stop beat always ends the arc
	a_stop_ends: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_STOP |=> !active_q && out_valid_q && done_q)
		else $error("stop did not end the arc");

	// The last tick of an arc flags done
	a_last_tick: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_TICK && active_q && left_q == count_t'(1)
		|=> done_q && !active_q)
		else $error("last tick did not flag done");

	// No move means no pulses and zero axis and direction
	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !moved_q |-> pulse_q == 8'd0 && !axis_q && !dir_q)
		else $error("result without move carries step data");

	// A result in the register is held while the output stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(xpos_q) && $stable(ypos_q))
		else $error("stalled result changed");

endmodule

`default_nettype wire
